/* design/svr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package svr_pkg;

  localparam int PHASE_BITS       = 32;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SAMPLE_BITS      = 16;
  localparam int LEVEL_W          = 14;
  localparam int FACTOR_W         = 17;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [1:0] OP_NOTE_OFF = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  localparam logic [1:0] CFG_SAMPLE_RATE   = 2'd0;
  localparam logic [1:0] CFG_RELEASE_DECAY = 2'd1;
  localparam logic [1:0] CFG_RELEASE_FLOOR = 2'd2;

  localparam logic [17:0] SAMPLE_RATE_RST   = 18'd48000;
  localparam logic [15:0] RELEASE_DECAY_RST = 16'd64881;
  localparam logic [15:0] RELEASE_FLOOR_RST = 16'd328;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'd65536;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
  localparam logic [63:0] SINE_AMP    = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // top octave (notes 120..131) in Hz, Q16.16
  localparam logic [29:0] TOP_OCTAVE_Q16 [12] = '{
    30'd548668578, 30'd581294109, 30'd615859655, 30'd652480577,
    30'd691279090, 30'd732384684, 30'd775934544, 30'd822074013,
    30'd870957077, 30'd922746880, 30'd977616265, 30'd1035748353
  };

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  note_number;
    logic [15:0] note_velocity;
    logic        allow_release;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          voice_active;
    logic                          releasing;
  } out_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [6:0]         note;
    logic [LEVEL_W-1:0] level;
    logic               allow_release;
  } cmd_t;

  typedef struct packed {
    logic [17:0] sample_rate;
    logic [15:0] release_decay;
    logic [15:0] release_floor;
  } cfg_t;

  // note / 12 by compares
  function automatic logic [3:0] note_octave(logic [6:0] n);
    logic [3:0] o;
    o = '0;
    for (int k = 1; k <= 10; k++) begin
      if (n >= 7'(12 * k)) begin
        o = o + 4'd1;
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

/* design/svr_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module svr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire svr_pkg::in_t  item,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output svr_pkg::cmd_t      cmd
);

  localparam int PW = $clog2(svr_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(svr_pkg::QUEUE_DEPTH + 1);

  svr_pkg::cmd_t    slots [svr_pkg::QUEUE_DEPTH];
  svr_pkg::cmd_t    decoded;
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  always_comb begin
    decoded               = '0;
    decoded.op            = item.opcode;
    decoded.allow_release = item.allow_release;
    if (item.opcode == svr_pkg::OP_NOTE_ON) begin
      decoded.note  = item.note_number;
      decoded.level = item.note_velocity[15:2];
    end
  end

  assign item_ready = (count != CW'(svr_pkg::QUEUE_DEPTH));
  assign cmd_valid  = (count != '0);
  assign cmd        = slots[rd_ptr];
  assign push       = item_valid && item_ready;
  assign pop        = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(svr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(svr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* design/svr_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle, rounds half up via added half divisor
module svr_div #(
  parameter int PHASE_BITS = svr_pkg::PHASE_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [PHASE_BITS+13:0]  num,
  input  wire logic [17:0]             den,
  output logic                         done,
  output logic [PHASE_BITS-1:0]        quot
);

  localparam int DVW = PHASE_BITS + 15;
  localparam int CW  = $clog2(DVW + 1);

  logic [DVW-1:0] dvd;
  logic [17:0]    rem;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [18:0]    rem_sh;
  logic [18:0]    diff;
  logic           ge;

  assign rem_sh = {rem, dvd[DVW-1]};
  assign diff   = rem_sh - {1'b0, den};
  assign ge     = (rem_sh >= {1'b0, den});
  assign quot   = dvd[PHASE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= DVW'(num) + DVW'(den[17:1]);
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVW-2:0], ge};
      rem <= ge ? diff[17:0] : rem_sh[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/svr_rom.sv */
`timescale 1ns / 1ps
`default_nettype none

// sine ROM: entry = {negative, magnitude}, registered read
module svr_rom #(
  parameter int PHASE_BITS       = svr_pkg::PHASE_BITS,
  parameter int SINE_TABLE_DEPTH = svr_pkg::SINE_TABLE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic [PHASE_BITS-1:0]         phase,
  output logic [svr_pkg::SAMPLE_BITS-1:0]    rom_q
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam int SB = svr_pkg::SAMPLE_BITS;

  typedef logic [SB-1:0] rom_t [SINE_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    logic        neg;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      a   = (64'(i) * svr_pkg::Q30_TWO_PI) / SINE_TABLE_DEPTH;
      neg = 1'b0;
      if (a >= svr_pkg::Q30_PI) begin
        neg = 1'b1;
        a   = a - svr_pkg::Q30_PI;
      end
      if (a > svr_pkg::Q30_HALF_PI) begin
        a = svr_pkg::Q30_PI - a;
      end
      x2 = (a * a) >> 30;
      t  = svr_pkg::Q30_ONE;
      for (int k = 0; k < 6; k++) begin
        t = svr_pkg::Q30_ONE - (((x2 * t) >> 30) / svr_pkg::TAYLOR_DIV[k]);
      end
      s = (a * t) >> 30;
      if (s > svr_pkg::Q30_ONE) begin
        s = svr_pkg::Q30_ONE;
      end
      mag  = (s * svr_pkg::SINE_AMP + (64'd1 << 29)) >> 30;
      r[i] = {neg, mag[SB-2:0]};
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [PHASE_BITS+IW-1:0] scaled;
  logic [IW-1:0]            idx;

  assign scaled = (PHASE_BITS + IW)'(phase) * (PHASE_BITS + IW)'(SINE_TABLE_DEPTH);
  assign idx    = scaled[PHASE_BITS+IW-1:PHASE_BITS];

  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[idx];
  end

endmodule

`default_nettype wire

/* design/svr_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module svr_back #(
  parameter int PHASE_BITS       = svr_pkg::PHASE_BITS,
  parameter int SINE_TABLE_DEPTH = svr_pkg::SINE_TABLE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire svr_pkg::cmd_t  cmd,
  input  wire svr_pkg::cfg_t  cfg,
  output logic                result_valid,
  input  wire logic           result_ready,
  output svr_pkg::out_t       result
);

  localparam int SB    = svr_pkg::SAMPLE_BITS;
  localparam int MAG_W = SB - 1;
  localparam int LVL_W = svr_pkg::LEVEL_W;
  localparam int RF_W  = svr_pkg::FACTOR_W;
  localparam int NUM_W = PHASE_BITS + 14;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ROM  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]            state;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_step;
  logic [LVL_W-1:0]      note_level;
  logic [RF_W-1:0]       release_factor;
  logic                  active;

  logic                  live;
  logic                  rel;
  logic                  neg;
  logic [MAG_W-1:0]      mag1;
  logic [MAG_W-1:0]      mag2;
  logic [RF_W-1:0]       rf_dec;

  logic [3:0]            oct;
  logic [3:0]            semi;
  logic [NUM_W-1:0]      num;
  logic [17:0]           sr_eff;
  logic                  div_start;
  logic                  div_done;
  logic [PHASE_BITS-1:0] div_quot;
  logic [SB-1:0]         rom_q;
  logic [MAG_W+LVL_W-1:0] prod1;
  logic [MAG_W+RF_W-1:0]  prod2;
  logic [RF_W+15:0]       rf_prod;
  logic [SB-1:0]         smag;
  logic                  out_free;

  assign oct    = svr_pkg::note_octave(cmd.note);
  assign semi   = 4'(cmd.note - 7'(7'(oct) * 7'd12));
  assign num    = (NUM_W'(svr_pkg::TOP_OCTAVE_Q16[semi]) << (PHASE_BITS - 16)) >> (4'd10 - oct);
  assign sr_eff = (cfg.sample_rate == '0) ? 18'd1 : cfg.sample_rate;

  assign cmd_ready = (state == ST_IDLE);
  assign div_start = cmd_ready && cmd_valid && (cmd.op == svr_pkg::OP_NOTE_ON);

  assign prod1    = (MAG_W + LVL_W)'(rom_q[MAG_W-1:0]) * (MAG_W + LVL_W)'(note_level);
  assign rf_prod  = (RF_W + 16)'(release_factor) * (RF_W + 16)'(cfg.release_decay);
  assign prod2    = (MAG_W + RF_W)'(mag1) * (MAG_W + RF_W)'(release_factor);
  assign smag     = SB'(mag2);
  assign out_free = !result_valid || result_ready;

  svr_div #(
    .PHASE_BITS (PHASE_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (sr_eff),
    .done  (div_done),
    .quot  (div_quot)
  );

  svr_rom #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk   (clk),
    .phase (phase_acc),
    .rom_q (rom_q)
  );

  always_ff @(posedge clk) begin
    if (state == ST_ROM) begin
      neg    <= rom_q[SB-1];
      mag1   <= MAG_W'(prod1 >> 16);
      rf_dec <= RF_W'(rf_prod >> 16);
    end
    if (state == ST_MUL) begin
      mag2 <= rel ? MAG_W'(prod2 >> 16) : mag1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      phase_acc      <= '0;
      phase_step     <= '0;
      note_level     <= '0;
      release_factor <= '0;
      active         <= 1'b0;
      live           <= 1'b0;
      rel            <= 1'b0;
      result_valid   <= 1'b0;
      result         <= '0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              svr_pkg::OP_NOTE_ON: begin
                phase_acc      <= '0;
                note_level     <= cmd.level;
                release_factor <= '0;
                active         <= 1'b1;
                state          <= ST_DIV;
              end
              svr_pkg::OP_NOTE_OFF: begin
                if (cmd.allow_release && release_factor == '0) begin
                  release_factor <= svr_pkg::FACTOR_ONE;
                end else begin
                  active     <= 1'b0;
                  phase_step <= '0;
                end
              end
              svr_pkg::OP_CLEAR: begin
                active     <= 1'b0;
                phase_step <= '0;
              end
              svr_pkg::OP_TICK: begin
                live  <= active;
                rel   <= active && (release_factor != '0);
                state <= active ? ST_ROM : ST_OUT;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            phase_step <= div_quot;
            state      <= ST_IDLE;
          end
        end
        ST_ROM: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
            if (live) begin
              result.sample_out   <= neg ? -smag : smag;
              result.voice_active <= 1'b1;
              result.releasing    <= rel;
              phase_acc           <= phase_acc + phase_step;
              if (rel) begin
                release_factor <= rf_dec;
                if (rf_dec <= RF_W'(cfg.release_floor)) begin
                  active     <= 1'b0;
                  phase_step <= '0;
                end
              end
            end else begin
              result <= '0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/sine_voice_with_release.sv */
`timescale 1ns / 1ps
`default_nettype none

// One sine voice with exponential release.
// Input channel item_valid/item_ready/item carries commands: sample tick,
// note on, note off, clear. Only a sample tick yields a result, on
// result_valid/result_ready/result; an idle voice yields a zero sample.
// Commands pass through a two-entry queue to the execution side, so the
// input keeps taking transfers while a result waits at the output.
// Execution steps per command:
//   sample tick   ROM read, level multiply, release multiply, output;
//                 output only while the voice is idle
//   note on       the bit-serial phase step divider, one quotient bit
//                 per cycle
//   note off, clear handled directly in the idle state
// While the receiver stalls, the result holds in the output register and a
// following tick waits in its output stage; the queue then fills and
// item_ready drops.
// Configuration (cfg_we/cfg_index/cfg_data) is to be written while idle only; the block does not enforce it.
// Synchronous reset restores default configuration, empties the queue and
// silences the voice.
module sine_voice_with_release #(
  parameter int PHASE_BITS       = svr_pkg::PHASE_BITS,
  parameter int SINE_TABLE_DEPTH = svr_pkg::SINE_TABLE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire svr_pkg::in_t  item,
  output logic               result_valid,
  input  wire logic          result_ready,
  output svr_pkg::out_t      result,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [17:0]   cfg_data
);

  svr_pkg::cfg_t cfg;
  svr_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_rate   <= svr_pkg::SAMPLE_RATE_RST;
      cfg.release_decay <= svr_pkg::RELEASE_DECAY_RST;
      cfg.release_floor <= svr_pkg::RELEASE_FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        svr_pkg::CFG_SAMPLE_RATE:   cfg.sample_rate   <= cfg_data;
        svr_pkg::CFG_RELEASE_DECAY: cfg.release_decay <= cfg_data[15:0];
        svr_pkg::CFG_RELEASE_FLOOR: cfg.release_floor <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  svr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  svr_back #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.voice_active |-> result.sample_out == '0 && !result.releasing)
    else $error("idle result not silent");

  a_rel_active: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.releasing |-> result.voice_active)
    else $error("release flagged on inactive voice");

  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("queued command lost while execution busy");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && cmd_ready && !cmd_valid)
    else $error("reset did not clear control state");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  typedef logic [63:0] u64_t;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int TAIL_CYCLES   = 200;
  localparam int HOLD_CYCLES   = 400;

  // angle constants (Q30), sine amplitude, Q16.16 unity
  localparam u64_t K_ONE     = 64'd1073741824;
  localparam u64_t K_PI      = 64'd3373259426;
  localparam u64_t K_HALF_PI = 64'd1686629713;
  localparam u64_t K_TWO_PI  = 64'd6746518852;
  localparam u64_t K_AMP     = 64'd32767;
  localparam u64_t K_UNITY   = 64'd65536;

  localparam u64_t SERIES_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // notes 120..131 in Hz, Q16.16
  localparam u64_t OCTAVE_HZ [12] = '{
    64'd548668578, 64'd581294109, 64'd615859655, 64'd652480577,
    64'd691279090, 64'd732384684, 64'd775934544, 64'd822074013,
    64'd870957077, 64'd922746880, 64'd977616265, 64'd1035748353
  };

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          item_valid = 1'b0;
  logic          item_ready;
  svr_pkg::in_t  item = '0;
  logic          result_valid;
  logic          result_ready = 1'b0;
  svr_pkg::out_t result;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_index = svr_pkg::CFG_SAMPLE_RATE;
  logic [17:0]   cfg_data = '0;

  sine_voice_with_release uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // voice state as predicted
  u64_t        rate_hz   = 64'd48000;
  u64_t        decay_q16 = 64'd64881;
  u64_t        floor_q16 = 64'd328;
  logic [31:0] osc_phase = '0;
  logic [31:0] osc_step  = '0;
  logic [15:0] osc_level = '0;
  logic [16:0] tail_factor = '0;
  logic        osc_on = 1'b0;

  svr_pkg::out_t expected_samples[$];

  int err_count     = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int release_count = 0;
  int setting_count = 0;
  int cycle_count   = 0;

  int       burst_left = 0;
  bit       tx_gaps = 1'b1;
  int       rx_hold_req = 0;
  int       rx_hold_left = 0;
  int       rx_mode_left = 0;
  int       rx_tick = 0;
  rx_mode_t rx_mode = RX_FLOW;

  // {negative, magnitude}
  function automatic logic [16:0] sine_entry(logic [9:0] idx);
    u64_t a, x2, t, s, mag;
    logic neg;
    int k;
    a = (u64_t'(idx) * K_TWO_PI) / 64'd1024;
    neg = 1'b0;
    if (a >= K_PI) begin
      neg = 1'b1;
      a = a - K_PI;
    end
    if (a > K_HALF_PI) begin
      a = K_PI - a;
    end
    x2 = (a * a) >> 30;
    t = K_ONE;
    for (k = 0; k < 6; k++) begin
      t = K_ONE - ((x2 * t) >> 30) / SERIES_DIV[k];
    end
    s = (a * t) >> 30;
    if (s > K_ONE) begin
      s = K_ONE;
    end
    mag = (s * K_AMP + (64'd1 << 29)) >> 30;
    return {neg, mag[15:0]};
  endfunction

  function automatic logic [31:0] note_phase_step(logic [6:0] n);
    u64_t num, rate;
    int octave;
    octave = int'(n) / 12;
    num = (OCTAVE_HZ[int'(n) % 12] << 16) >> (10 - octave);
    rate = (rate_hz == 0) ? 64'd1 : rate_hz;
    return 32'((num + rate / 2) / rate);
  endfunction

  task automatic voice_predict(input svr_pkg::in_t c);
    svr_pkg::out_t smp;
    logic [16:0]   rom;
    u64_t          mag;
    logic          rel;
    case (c.opcode)
      svr_pkg::OP_NOTE_ON: begin
        osc_phase = '0;
        osc_level = c.note_velocity >> 2;
        tail_factor = '0;
        osc_step = note_phase_step(c.note_number);
        osc_on = 1'b1;
      end
      svr_pkg::OP_NOTE_OFF: begin
        if (c.allow_release && tail_factor == 0) begin
          tail_factor = 17'(K_UNITY);
        end else begin
          osc_on = 1'b0;
          osc_step = '0;
        end
      end
      svr_pkg::OP_CLEAR: begin
        osc_on = 1'b0;
        osc_step = '0;
      end
      default: begin
        smp = '0;
        if (osc_on) begin
          rel = (tail_factor != 0);
          rom = sine_entry(osc_phase[31:22]);
          mag = (u64_t'(rom[15:0]) * u64_t'(osc_level)) >> 16;
          if (rel) begin
            mag = (mag * u64_t'(tail_factor)) >> 16;
          end
          smp.sample_out = rom[16] ? 16'(64'd0 - mag) : 16'(mag);
          smp.voice_active = 1'b1;
          smp.releasing = rel;
          osc_phase = osc_phase + osc_step;
          if (rel) begin
            tail_factor = 17'((u64_t'(tail_factor) * decay_q16) >> 16);
            if (u64_t'(tail_factor) <= floor_q16) begin
              osc_on = 1'b0;
              osc_step = '0;
            end
          end
        end
        expected_samples.push_back(smp);
      end
    endcase
  endtask

  // one command transfer; the sender runs in bursts with random gaps while tx_gaps is set
  task automatic send_cmd(input svr_pkg::in_t c);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (tx_gaps) begin
        gap = $urandom_range(0, 6);
      end
    end
    burst_left--;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= c;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    voice_predict(c);
    sent_count++;
  endtask

  function automatic svr_pkg::in_t make_cmd(logic [1:0] op);
    logic [31:0]  r;
    svr_pkg::in_t c;
    r = $urandom;
    c = r[$bits(svr_pkg::in_t)-1:0];
    c.opcode = op;
    return c;
  endfunction

  task automatic send_op(input logic [1:0] op);
    send_cmd(make_cmd(op));
  endtask

  task automatic send_note_on(input logic [6:0] n, input logic [15:0] vel);
    svr_pkg::in_t c;
    c = make_cmd(svr_pkg::OP_NOTE_ON);
    c.note_number = n;
    c.note_velocity = vel;
    send_cmd(c);
  endtask

  task automatic send_note_off(input logic tail);
    svr_pkg::in_t c;
    c = make_cmd(svr_pkg::OP_NOTE_OFF);
    c.allow_release = tail;
    send_cmd(c);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_op(svr_pkg::OP_TICK);
  endtask

  // stop offering, wait for every sample, then let queued commands finish
  task automatic drain_voice();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [17:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      svr_pkg::CFG_SAMPLE_RATE:   rate_hz = u64_t'(val);
      svr_pkg::CFG_RELEASE_DECAY: decay_q16 = u64_t'(val[15:0]);
      svr_pkg::CFG_RELEASE_FLOOR: floor_q16 = u64_t'(val[15:0]);
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [17:0] rate, input logic [15:0] decay,
                               input logic [15:0] floor_level);
    drain_voice();
    cfg_write(svr_pkg::CFG_SAMPLE_RATE, rate);
    cfg_write(svr_pkg::CFG_RELEASE_DECAY, 18'(decay));
    cfg_write(svr_pkg::CFG_RELEASE_FLOOR, 18'(floor_level));
    setting_count++;
  endtask

  // note on, sustain, then usually some way of ending it
  task automatic play_phrase();
    logic [15:0] vel;
    int sel;
    case ($urandom_range(0, 5))
      0:       vel = 16'hFFFF;
      1:       vel = 16'h0000;
      default: vel = 16'($urandom);
    endcase
    send_note_on(7'($urandom), vel);
    send_ticks($urandom_range(0, 30));
    sel = $urandom_range(0, 9);
    if (sel <= 6) begin
      send_note_off(1'b1);
      if ($urandom_range(0, 9) == 0) begin
        send_ticks($urandom_range(100, 700));
      end else begin
        send_ticks($urandom_range(0, 40));
      end
      if ($urandom_range(0, 4) == 0) begin
        send_note_off($urandom_range(0, 1));
        send_ticks($urandom_range(0, 4));
      end
    end else if (sel == 7) begin
      send_note_off(1'b0);
      send_ticks($urandom_range(0, 4));
    end else if (sel == 8) begin
      send_op(svr_pkg::OP_CLEAR);
      send_ticks($urandom_range(0, 4));
    end
  endtask

  task automatic run_random(input int n);
    int target;
    target = sent_count + n;
    while (sent_count < target) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
        play_phrase();
      end else begin
        repeat ($urandom_range(1, 4)) send_op(2'($urandom));
      end
    end
    tx_gaps = 1'b1;
  endtask

  task automatic test_directed();
    send_op(svr_pkg::OP_TICK);
    send_note_off(1'b1);
    send_op(svr_pkg::OP_TICK);
    send_note_on(7'd0, 16'hFFFF);
    send_ticks(3);
    send_note_on(7'd127, 16'h0000);
    send_op(svr_pkg::OP_TICK);
    send_note_on(7'd69, 16'hFFFF);
    send_ticks(3);
    send_note_off(1'b1);
    send_ticks(2);
    send_note_off(1'b1);
    send_op(svr_pkg::OP_TICK);
    send_note_on(7'd60, 16'h8000);
    send_op(svr_pkg::OP_TICK);
    send_note_off(1'b0);
    send_op(svr_pkg::OP_TICK);
    send_note_on(7'd100, 16'h1234);
    send_op(svr_pkg::OP_CLEAR);
    send_op(svr_pkg::OP_TICK);
  endtask

  // receiver holds off while the sender keeps offering ticks
  task automatic test_backpressure();
    drain_voice();
    tx_gaps = 1'b0;
    burst_left = 0;
    rx_hold_req = HOLD_CYCLES;
    send_note_on(7'd81, 16'hC000);
    send_ticks(40);
    send_note_off(1'b1);
    send_ticks(20);
    tx_gaps = 1'b1;
    drain_voice();
  endtask

  task automatic test_settings();
    apply_setting(18'd48000, 16'd64881, 16'd328);
    run_random(260);
    apply_setting(18'd8000, 16'd0, 16'd0);
    run_random(230);
    apply_setting(18'd192000, 16'hFFFF, 16'hFFFF);
    send_note_on(7'd64, 16'hFFFF);
    send_op(svr_pkg::OP_TICK);
    send_note_off(1'b1);
    send_ticks(2);
    run_random(230);
    apply_setting(18'd44100, 16'd50000, 16'd328);
    run_random(260);
    apply_setting(18'd0, 16'd60000, 16'd1000);
    run_random(230);
    apply_setting(18'h3FFFF, 16'hFFFF, 16'd0);
    run_random(230);
    apply_setting(18'($urandom_range(8000, 192000)), 16'($urandom_range(30000, 65535)),
                  16'($urandom_range(0, 4000)));
    run_random(260);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_settings();
    drain_voice();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d commands over %0d register settings, incl. long receiver hold-off",
             sent_count, setting_count);
    $display("checked %0d samples (%0d in release tail), %0d mismatches",
             checked_count, release_count, err_count);
    if (err_count == 0) begin
      $display("sine_voice_with_release regression: pass");
    end else begin
      $display("sine_voice_with_release regression: fail");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    rx_tick++;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      result_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(16, 160);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_FLOW:  result_ready <= 1'b1;
        RX_LIGHT: result_ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: result_ready <= ($urandom_range(0, 3) == 0);
        default:  result_ready <= ((rx_tick % 5) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    svr_pkg::out_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample transfer %h", $time, result);
        err_count++;
      end else begin
        want = expected_samples.pop_front();
        checked_count++;
        if (want.releasing) begin
          release_count++;
        end
        if (result.sample_out !== want.sample_out) begin
          $display("%0t: sample_out expected %0d actual %0d", $time,
                   want.sample_out, result.sample_out);
          err_count++;
        end
        if (result.voice_active !== want.voice_active) begin
          $display("%0t: voice_active expected %b actual %b", $time,
                   want.voice_active, result.voice_active);
          err_count++;
        end
        if (result.releasing !== want.releasing) begin
          $display("%0t: releasing expected %b actual %b", $time,
                   want.releasing, result.releasing);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycle_count,
               expected_samples.size());
      $display("sine_voice_with_release regression: fail");
      $finish;
    end
  end

endmodule

/* sine_voice_with_release.f */
design/svr_pkg.sv
design/svr_front.sv
design/svr_div.sv
design/svr_rom.sv
design/svr_back.sv
design/sine_voice_with_release.sv
verif/tb_top.sv
